@@ design/bwlp_pkg.sv @@
package bwlp_pkg;

  localparam int DEF_SAMPLE_BITS    = 24;
  localparam int DEF_COEF_FRAC_BITS = 22;

  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 4;

  typedef enum logic [1:0] {
    REG_GAIN_K       = 2'd0,
    REG_FEEDBACK_ONE = 2'd1,
    REG_FEEDBACK_TWO = 2'd2,
    REG_BYPASS_ON    = 2'd3
  } reg_idx_t;

endpackage

@@ design/bwlp_regs.sv @@
module bwlp_regs
  import bwlp_pkg::*;
#(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0]          cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0]          cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0]          cfg_prdata,
  output logic                              cfg_pready,
  output logic [COEF_FRAC_BITS:0]           gain_k,
  output logic signed [COEF_FRAC_BITS+1:0]  feedback_one,
  output logic [COEF_FRAC_BITS:0]           feedback_two,
  output logic                              bypass_on
);

  localparam int K_BITS   = COEF_FRAC_BITS + 1;
  localparam int FB1_BITS = COEF_FRAC_BITS + 2;
  localparam int FB2_BITS = COEF_FRAC_BITS + 1;

  logic [K_BITS-1:0]          gain_k_r;
  logic signed [FB1_BITS-1:0] feedback_one_r;
  logic [FB2_BITS-1:0]        feedback_two_r;
  logic                       bypass_on_r;
  logic                       wr_en;
  reg_idx_t                   reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_k_r       <= '0;
      feedback_one_r <= '0;
      feedback_two_r <= '0;
      bypass_on_r    <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAIN_K:       gain_k_r       <= cfg_pwdata[K_BITS-1:0];
        REG_FEEDBACK_ONE: feedback_one_r <= $signed(cfg_pwdata[FB1_BITS-1:0]);
        REG_FEEDBACK_TWO: feedback_two_r <= cfg_pwdata[FB2_BITS-1:0];
        REG_BYPASS_ON:    bypass_on_r    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_K:       cfg_prdata = CFG_DATA_BITS'(gain_k_r);
      REG_FEEDBACK_ONE: cfg_prdata = CFG_DATA_BITS'(feedback_one_r);
      REG_FEEDBACK_TWO: cfg_prdata = CFG_DATA_BITS'(feedback_two_r);
      REG_BYPASS_ON:    cfg_prdata = CFG_DATA_BITS'(bypass_on_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign gain_k       = gain_k_r;
  assign feedback_one = feedback_one_r;
  assign feedback_two = feedback_two_r;
  assign bypass_on    = bypass_on_r;

endmodule

@@ design/bwlp_core.sv @@
module bwlp_core
  import bwlp_pkg::*;
#(
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic signed [SAMPLE_BITS-1:0]    x,
  input  logic signed [SAMPLE_BITS-1:0]    x1,
  input  logic signed [SAMPLE_BITS-1:0]    x2,
  input  logic signed [SAMPLE_BITS-1:0]    y1,
  input  logic signed [SAMPLE_BITS-1:0]    y2,
  input  logic [COEF_FRAC_BITS:0]          gain_k,
  input  logic signed [COEF_FRAC_BITS+1:0] feedback_one,
  input  logic [COEF_FRAC_BITS:0]          feedback_two,
  input  logic                             bypass_on,
  output logic signed [SAMPLE_BITS-1:0]    y,
  output logic                             clipped
);

  localparam int S     = SAMPLE_BITS;
  localparam int F     = COEF_FRAC_BITS;
  localparam int T_W   = S + 2;
  localparam int PK_W  = S + F + 4;
  localparam int PF_W  = S + F + 2;
  localparam int ACC_W = S + F + 5;
  localparam int Q_W   = ACC_W - F;

  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (F - 1);
  localparam logic signed [Q_W-1:0]   Y_MAX = {{(Q_W-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [Q_W-1:0]   Y_MIN = {{(Q_W-S+1){1'b1}}, {(S-1){1'b0}}};

  logic signed [T_W-1:0]   tap_sum;
  logic signed [F+1:0]     gain_s;
  logic signed [F+1:0]     fb2_s;
  logic signed [PK_W-1:0]  prod_k;
  logic signed [PF_W-1:0]  prod_fb1;
  logic signed [PF_W-1:0]  prod_fb2;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [Q_W-1:0]   q;

  always_comb begin
    tap_sum  = T_W'(x) + (T_W'(x1) <<< 1) + T_W'(x2);
    gain_s   = $signed({1'b0, gain_k});
    fb2_s    = $signed({1'b0, feedback_two});
    prod_k   = gain_s * tap_sum;
    prod_fb1 = feedback_one * y1;
    prod_fb2 = fb2_s * y2;
    acc      = ACC_W'(prod_k) - ACC_W'(prod_fb1) - ACC_W'(prod_fb2) + HALF;
    // arithmetic shift gives floor, so adding half first rounds ties upward
    acc_sh   = acc >>> F;
    q        = $signed(acc_sh[Q_W-1:0]);

    if (bypass_on) begin
      y       = x;
      clipped = 1'b0;
    end else if (q > Y_MAX) begin
      y       = $signed(Y_MAX[S-1:0]);
      clipped = 1'b1;
    end else if (q < Y_MIN) begin
      y       = $signed(Y_MIN[S-1:0]);
      clipped = 1'b1;
    end else begin
      y       = $signed(q[S-1:0]);
      clipped = 1'b0;
    end
  end

endmodule

@@ design/butterworth_lowpass_biquad.sv @@
// Second-order low-pass biquad in direct form I: y = k*(x + 2*x1 + x2) - a1*y1 - a2*y2 with
// round-to-nearest and saturation to the sample width, or a straight copy of the input when
// bypass_on is set. One sample is accepted per clock unless out_stall holds the output, a
// rate set by the loop from the previous output through the three multipliers and the
// accumulate back into the output history; each result passes the stage 1 register, then
// the output register. clear_history zeroes the history before its own sample in either
// mode. Coefficients are written over the APB port (k, a2 as unsigned Q1.COEF_FRAC_BITS,
// a1 as signed Q2.COEF_FRAC_BITS) and must only change while no samples are in flight.
module butterworth_lowpass_biquad
  import bwlp_pkg::*;
#(
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          in_clear_history,
  input  logic                          in_block_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_clipped,
  output logic                          out_block_end_out,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0]      cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0]      cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0]      cfg_prdata,
  output logic                          cfg_pready
);

  localparam int S = SAMPLE_BITS;
  localparam int F = COEF_FRAC_BITS;

  logic [F:0]            gain_k;
  logic signed [F+1:0]   feedback_one;
  logic [F:0]            feedback_two;
  logic                  bypass_on;

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic signed [S-1:0]   s1_sample_r;
  logic                  s1_clr_r;
  logic                  s1_end_r;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic signed [S-1:0]   out_sample_r;
  logic                  out_clip_r;
  logic                  out_end_r;

  logic signed [S-1:0]   x1_r, x2_r, y1_r, y2_r;
  logic signed [S-1:0]   x1_nxt, x2_nxt, y1_nxt, y2_nxt;
  logic signed [S-1:0]   x1_eff, x2_eff, y1_eff, y2_eff;

  logic                  in_accept;
  logic                  advance;
  logic signed [S-1:0]   y;
  logic                  clipped;

  bwlp_regs #(
    .COEF_FRAC_BITS(F)
  ) u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .gain_k       (gain_k),
    .feedback_one (feedback_one),
    .feedback_two (feedback_two),
    .bypass_on    (bypass_on)
  );

  // stage 1 moves on whenever the output register is empty or being drained
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // clear takes effect ahead of this sample
  assign x1_eff = s1_clr_r ? '0 : x1_r;
  assign x2_eff = s1_clr_r ? '0 : x2_r;
  assign y1_eff = s1_clr_r ? '0 : y1_r;
  assign y2_eff = s1_clr_r ? '0 : y2_r;

  bwlp_core #(
    .SAMPLE_BITS    (S),
    .COEF_FRAC_BITS (F)
  ) u_core (
    .x            (s1_sample_r),
    .x1           (x1_eff),
    .x2           (x2_eff),
    .y1           (y1_eff),
    .y2           (y2_eff),
    .gain_k       (gain_k),
    .feedback_one (feedback_one),
    .feedback_two (feedback_two),
    .bypass_on    (bypass_on),
    .y            (y),
    .clipped      (clipped)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    x1_nxt = x1_r;
    x2_nxt = x2_r;
    y1_nxt = y1_r;
    y2_nxt = y2_r;
    if (advance) begin
      if (!bypass_on) begin
        x1_nxt = s1_sample_r;
        x2_nxt = x1_eff;
        y1_nxt = y;
        y2_nxt = y1_eff;
      end else begin
        x1_nxt = x1_eff;
        x2_nxt = x2_eff;
        y1_nxt = y1_eff;
        y2_nxt = y2_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      x1_r        <= x1_nxt;
      x2_r        <= x2_nxt;
      y1_r        <= y1_nxt;
      y2_r        <= y2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r <= in_sample_in;
      s1_clr_r    <= in_clear_history;
      s1_end_r    <= in_block_end;
    end
    if (advance) begin
      out_sample_r <= y;
      out_clip_r   <= clipped;
      out_end_r    <= s1_end_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_out    = out_sample_r;
  assign out_clipped       = out_clip_r;
  assign out_block_end_out = out_end_r;

  // filtered result lands in the output history together with the output register
  a_out_matches_history: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !bypass_on |=> out_sample_r == y1_r)
    else $error("filtered output and y1 history disagree");

  // bypass without clear leaves the history alone
  a_bypass_keeps_history: assert property (@(posedge clk) disable iff (!rst_n)
    advance && bypass_on && !s1_clr_r |=> $stable(x1_r) && $stable(x2_r)
      && $stable(y1_r) && $stable(y2_r))
    else $error("history changed on a bypassed transaction");

  // a clear in bypass leaves zero history behind
  a_bypass_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    advance && bypass_on && s1_clr_r |=> x1_r == '0 && y1_r == '0)
    else $error("clear in bypass did not zero history");

  a_no_clip_in_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && bypass_on |-> !out_clip_r)
    else $error("clip flagged on a bypassed sample");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import bwlp_pkg::*;

  localparam int SB = DEF_SAMPLE_BITS;
  localparam int FRAC = DEF_COEF_FRAC_BITS;
  localparam longint SAMPLE_MAX = (longint'(1) << (SB - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam logic signed [SB-1:0] FULL_POS = {1'b0, {(SB - 1){1'b1}}};
  localparam logic signed [SB-1:0] FULL_NEG = {1'b1, {(SB - 1){1'b0}}};
  localparam logic signed [SB-1:0] HALF_LSB = SB'(longint'(1) << (FRAC - 1));

  typedef struct packed {
    logic [SB-1:0] sample;
    logic          clipped;
    logic          block_end;
  } filter_out_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [SB-1:0]     in_sample_in = '0;
  logic                     in_clear_history = 1'b0;
  logic                     in_block_end = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [SB-1:0]     out_sample_out;
  logic                     out_clipped;
  logic                     out_block_end_out;
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  // shadow of the block's registers and sample history
  longint coef_k = 0;
  longint coef_a1 = 0;
  longint coef_a2 = 0;
  bit     bypass_mode = 1'b1;
  longint x_d1 = 0;
  longint x_d2 = 0;
  longint y_d1 = 0;
  longint y_d2 = 0;

  filter_out_t expected_samples[$];
  filter_out_t head_result;
  int          errors = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  logic        hold_off = 1'b0;

  butterworth_lowpass_biquad i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_in      (in_sample_in),
    .in_clear_history  (in_clear_history),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_out    (out_sample_out),
    .out_clipped       (out_clipped),
    .out_block_end_out (out_block_end_out),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected transaction: sample_out %0d", out_sample_out);
        errors++;
      end else begin
        head_result = expected_samples.pop_front();
        if (head_result.sample !== out_sample_out) begin
          $error("sample_out: expected %0d, got %0d", $signed(head_result.sample),
                 out_sample_out);
          errors++;
        end
        if (head_result.clipped !== out_clipped) begin
          $error("clipped: expected %0d, got %0d", head_result.clipped, out_clipped);
          errors++;
        end
        if (head_result.block_end !== out_block_end_out) begin
          $error("block_end_out: expected %0d, got %0d", head_result.block_end,
                 out_block_end_out);
          errors++;
        end
      end
    end
  end

  // direct form I step: clear first, then filter or copy
  task automatic filter_sample(input logic signed [SB-1:0] smp, input logic clr,
                               input logic last);
    longint x;
    longint acc;
    longint y;
    filter_out_t res;
    x = longint'(smp);
    y = x;
    res.clipped = 1'b0;
    if (clr) begin
      x_d1 = 0;
      x_d2 = 0;
      y_d1 = 0;
      y_d2 = 0;
    end
    if (!bypass_mode) begin
      acc = coef_k * (x + 2 * x_d1 + x_d2) - coef_a1 * y_d1 - coef_a2 * y_d2
            + (longint'(1) << (FRAC - 1));
      y = acc >>> FRAC;
      if (y > SAMPLE_MAX) begin
        y = SAMPLE_MAX;
        res.clipped = 1'b1;
      end
      if (y < SAMPLE_MIN) begin
        y = SAMPLE_MIN;
        res.clipped = 1'b1;
      end
      x_d2 = x_d1;
      x_d1 = x;
      y_d2 = y_d1;
      y_d1 = y;
    end
    res.sample = y[SB-1:0];
    res.block_end = last;
    expected_samples.push_back(res);
  endtask

  task automatic send_sample(input logic signed [SB-1:0] smp, input logic clr,
                             input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= smp;
    in_clear_history <= clr;
    in_block_end <= last;
    do @(posedge clk); while (in_stall);
    filter_sample(smp, clr, last);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_GAIN_K:       coef_k = longint'(data[22:0]);
      REG_FEEDBACK_ONE: coef_a1 = longint'($signed(data[23:0]));
      REG_FEEDBACK_TWO: coef_a2 = longint'(data[22:0]);
      REG_BYPASS_ON:    bypass_mode = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // extreme or random register value, with noise above the register width
  function automatic logic [31:0] corner_value(int unsigned width);
    logic [31:0] mask;
    logic [31:0] noise;
    mask = (32'd1 << width) - 32'd1;
    noise = $urandom;
    case ($urandom_range(3))
      0:       return noise & ~mask;
      1:       return noise | mask;
      2:       return (noise & ~mask) | (32'd1 << (width - 1));
      default: return noise;
    endcase
  endfunction

  task automatic apply_random_setting();
    real ratio;
    real w;
    real nrm;
    int unsigned style;
    style = $urandom_range(99);
    wait_idle();
    if (style < 70) begin
      // proper butterworth design at a random cutoff
      ratio = $urandom_range(5, 240) / 1000.0;
      w = $tan(3.141592653589793 * ratio);
      nrm = 1.0 / (1.0 + 1.4142135623730951 * w + w * w);
      write_reg(REG_GAIN_K, 32'(int'(w * w * nrm * 4194304.0)));
      write_reg(REG_FEEDBACK_ONE, 32'(int'(2.0 * (w * w - 1.0) * nrm * 4194304.0)));
      write_reg(REG_FEEDBACK_TWO,
                32'(int'((1.0 - 1.4142135623730951 * w + w * w) * nrm * 4194304.0)));
      write_reg(REG_BYPASS_ON, 32'd0);
    end else begin
      write_reg(REG_GAIN_K, corner_value(23));
      write_reg(REG_FEEDBACK_ONE, corner_value(24));
      write_reg(REG_FEEDBACK_TWO, corner_value(23));
      write_reg(REG_BYPASS_ON, (style < 88) ? 32'd0 : 32'd1);
    end
  endtask

  // buffers of random length with an end marker, some opened by a history clear
  task automatic send_random_run(input int count);
    int unsigned style;
    int blk_left;
    logic signed [SB-1:0] smp;
    logic clr;
    logic last;
    style = $urandom_range(3);
    blk_left = 0;
    for (int i = 0; i < count; i++) begin
      clr = 1'b0;
      if (blk_left == 0) begin
        blk_left = $urandom_range(1, 16);
        clr = ($urandom_range(9) == 0);
      end
      last = (blk_left == 1);
      blk_left--;
      case (style)
        1:       smp = SB'($signed(13'($urandom)));
        2:       smp = ((i / 8) % 2 == 0) ? FULL_POS : FULL_NEG;
        default: smp = SB'($urandom);
      endcase
      if ($urandom_range(9) == 0) begin
        clr = 1'($urandom);
        last = 1'($urandom);
      end
      send_sample(smp, clr, last);
    end
  endtask

  task automatic test_bypass_after_reset();
    send_sample(FULL_POS, 1'b0, 1'b0);
    send_sample(FULL_NEG, 1'b0, 1'b1);
    send_sample('0, 1'b1, 1'b0);
    send_sample('1, 1'b1, 1'b1);
    send_sample(SB'(24'h5A5A5A), 1'b0, 1'b0);
    wait_idle();
  endtask

  // k of one lsb makes the rounding step visible, ties go up
  task automatic test_rounding_ties();
    write_reg(REG_GAIN_K, 32'd1);
    write_reg(REG_FEEDBACK_ONE, 32'd0);
    write_reg(REG_FEEDBACK_TWO, 32'd0);
    write_reg(REG_BYPASS_ON, 32'd0);
    send_sample(HALF_LSB, 1'b1, 1'b0);
    send_sample(-HALF_LSB, 1'b1, 1'b0);
    send_sample(SB'(HALF_LSB - 1), 1'b1, 1'b0);
    send_sample(SB'(-HALF_LSB - 1), 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_saturation();
    write_reg(REG_GAIN_K, 32'h007F_FFFF);
    write_reg(REG_FEEDBACK_ONE, 32'h0080_0000);
    write_reg(REG_FEEDBACK_TWO, 32'h007F_FFFF);
    send_sample(FULL_POS, 1'b1, 1'b0);
    send_sample(FULL_POS, 1'b0, 1'b0);
    send_sample(FULL_NEG, 1'b0, 1'b0);
    send_sample(FULL_NEG, 1'b0, 1'b0);
    send_sample('0, 1'b0, 1'b0);
    send_sample('0, 1'b0, 1'b1);
    send_sample(FULL_NEG, 1'b1, 1'b1);
    wait_idle();
  endtask

  // bypass keeps the history, a clear in bypass still wipes it
  task automatic test_bypass_history();
    write_reg(REG_GAIN_K, 32'h0010_0000);
    write_reg(REG_FEEDBACK_ONE, 32'hFFC0_0000);
    write_reg(REG_FEEDBACK_TWO, 32'h0020_0000);
    send_sample(SB'(24'h300000), 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_BYPASS_ON, 32'd1);
    send_sample(SB'(24'h123456), 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_BYPASS_ON, 32'd0);
    send_sample(SB'(24'h100000), 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_BYPASS_ON, 32'd1);
    send_sample(SB'(24'h654321), 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_BYPASS_ON, 32'd0);
    send_sample(SB'(24'h100000), 1'b0, 1'b1);
    wait_idle();
  endtask

  // receiver holds off while the sender keeps going, so the input backs up
  task automatic test_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    apply_random_setting();
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    send_random_run(120);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int sent;
    int n;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 66;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 66;
        end
        default: begin
          in_idle_pct = 14;
          out_stall_pct = 14;
        end
      endcase
      sent = 0;
      while (sent < 310) begin
        apply_random_setting();
        n = $urandom_range(20, 80);
        send_random_run(n);
        sent += n;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bypass_after_reset();
    test_rounding_ties();
    test_saturation();
    test_bypass_history();
    test_backpressure();
    test_random_traffic();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
